// ===== rtl/core/acsn_pkg.sv =====
`default_nettype none

package acsn_pkg;

  // Line store depth and configuration reset values
  localparam int LINE_BYTES_DEF = 20;
  localparam logic [3:0] ATTEMPT_LIMIT_RST = 4'd10;
  localparam logic [7:0] REPLY_TIMEOUT_RST = 8'd100;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 1'd1;

  // Characters
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_F    = 8'h46;
  localparam logic [7:0] CHAR_H    = 8'h48;
  localparam logic [7:0] CHAR_K    = 8'h4B;
  localparam logic [7:0] CHAR_L    = 8'h4C;
  localparam logic [7:0] CHAR_O    = 8'h4F;
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_T    = 8'h54;

  // Sequence phases
  localparam logic [3:0] PH_PLUS0    = 4'd0;
  localparam logic [3:0] PH_PLUS1    = 4'd1;
  localparam logic [3:0] PH_PLUS2    = 4'd2;
  localparam logic [3:0] PH_OK_RX    = 4'd3;
  localparam logic [3:0] PH_OK_CHK   = 4'd4;
  localparam logic [3:0] PH_SH_RX    = 4'd5;
  localparam logic [3:0] PH_SH_PARSE = 4'd6;
  localparam logic [3:0] PH_SL_RX    = 4'd7;
  localparam logic [3:0] PH_SL_PARSE = 4'd8;
  localparam logic [3:0] PH_DONE     = 4'd9;

  // Status codes
  localparam logic [1:0] STAT_BUSY     = 2'd0;
  localparam logic [1:0] STAT_FINISHED = 2'd1;
  localparam logic [1:0] STAT_GAVE_UP  = 2'd2;

  // Command string sent by one tick
  typedef enum logic [1:0] {
    TX_NONE,
    TX_PLUS,
    TX_ATSH,
    TX_ATSL
  } tx_kind_t;

  localparam logic [2:0] CMD_LAST_IDX = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic walk_start;
    logic walk;
    logic apply;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_done;
    logic out_free;
    logic emit_last;
  } sts_t;

  // Byte at position idx of a command string
  function automatic logic [7:0] tx_byte(input tx_kind_t kind, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'd0;
    case (kind)
      TX_PLUS: b = CHAR_PLUS;
      TX_ATSH, TX_ATSL: begin
        case (idx)
          3'd0: b = CHAR_A;
          3'd1: b = CHAR_T;
          3'd2: b = CHAR_S;
          3'd3: b = (kind == TX_ATSH) ? CHAR_H : CHAR_L;
          default: b = CHAR_CR;
        endcase
      end
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acsn_ram.sv =====
`default_nettype none

module acsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = acsn_pkg::LINE_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/acsn_ctrl.sv =====
`default_nettype none

module acsn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire acsn_pkg::sts_t sts,
  output acsn_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WALK,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Sequence one tick: take it, walk the line if needed, update, emit items
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.need_walk) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_WALK;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          cmd.apply = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/acsn_dp.sv =====
`default_nettype none

module acsn_dp #(
  parameter int LINE_BYTES = acsn_pkg::LINE_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire acsn_pkg::cmd_t                 cmd,
  output acsn_pkg::sts_t                      sts,
  input  wire logic                           in_rx_present,
  input  wire logic [7:0]                     in_rx_data,
  input  wire logic                           cfg_wr_en,
  input  wire logic [acsn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic                                out_tx_present,
  output logic [7:0]                          out_tx_data,
  output logic                                out_flush_rx,
  output logic [1:0]                          out_status,
  output logic [31:0]                         out_serial_high,
  output logic [31:0]                         out_serial_low,
  output logic                                out_last
);

  localparam int AW = $clog2(LINE_BYTES);
  localparam int LW = $clog2(LINE_BYTES + 1);
  localparam logic [LW-1:0] LINE_MAX = LW'(LINE_BYTES);

  // Configuration
  logic [3:0] limit_r;
  logic [7:0] timeout_r;

  // Sequence state
  logic [3:0]    phase_r, phase_nxt;
  logic [3:0]    attempts_r, attempts_nxt;
  logic [7:0]    idle_r, idle_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [31:0]   high_r, high_nxt;
  logic [31:0]   low_r, low_nxt;
  logic          finished_r, finished_nxt;

  // Latched transaction
  logic       rx_present_r;
  logic [7:0] rx_data_r;

  // Line walk
  logic [LW-1:0] walk_idx_r, walk_idx_nxt;
  logic          pend_r, pend_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          bad_r, bad_nxt;
  logic          stop_r, stop_nxt;
  logic          first_ok_r, first_ok_nxt;
  logic          second_ok_r, second_ok_nxt;

  // Emission
  acsn_pkg::tx_kind_t kind_r, kind_nxt;
  logic               flush_r, flush_nxt;
  logic [2:0]         emit_idx_r;
  logic [2:0]         last_idx;

  // Line store
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  logic          run;
  logic [7:0]    c;
  logic          is_dec;
  logic          is_hex;
  logic [3:0]    dig;
  logic [31:0]   parsed;
  logic [1:0]    status_now;

  acsn_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (len_r[AW-1:0]),
    .wr_data (rx_data_r),
    .rd_en   (ram_re),
    .rd_addr (walk_idx_r[AW-1:0]),
    .rd_data (ram_rdata)
  );

  assign run = !finished_r && (attempts_r < limit_r);

  // Status toward the controller
  assign last_idx = (kind_r == acsn_pkg::TX_ATSH || kind_r == acsn_pkg::TX_ATSL)
                    ? acsn_pkg::CMD_LAST_IDX : 3'd0;
  always_comb begin
    sts.need_walk = run && (phase_r inside {acsn_pkg::PH_OK_CHK, acsn_pkg::PH_SH_PARSE,
                                            acsn_pkg::PH_SL_PARSE});
    sts.walk_done = !pend_r && (walk_idx_r >= len_r);
    sts.out_free  = !out_valid || out_ready;
    sts.emit_last = (emit_idx_r == last_idx);
  end

  // Decode one stored character as a hex digit
  assign c      = ram_rdata;
  assign is_dec = (c >= acsn_pkg::CHAR_0) && (c <= acsn_pkg::CHAR_9);
  assign is_hex = (c >= acsn_pkg::CHAR_A) && (c <= acsn_pkg::CHAR_F);
  assign dig    = is_dec ? 4'(c - acsn_pkg::CHAR_0) : 4'(c - acsn_pkg::CHAR_A + 8'd10);
  assign parsed = bad_r ? 32'hFFFF_FFFF : acc_r;

  // Walk the stored line one byte a cycle, reads pipelined one ahead
  assign ram_re = cmd.walk && (walk_idx_r < len_r);
  always_comb begin
    walk_idx_nxt  = walk_idx_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    bad_nxt       = bad_r;
    stop_nxt      = stop_r;
    first_ok_nxt  = first_ok_r;
    second_ok_nxt = second_ok_r;
    if (cmd.walk_start) begin
      walk_idx_nxt  = '0;
      pend_nxt      = 1'b0;
      acc_nxt       = '0;
      bad_nxt       = 1'b0;
      stop_nxt      = 1'b0;
      first_ok_nxt  = 1'b0;
      second_ok_nxt = 1'b0;
    end else if (cmd.walk) begin
      if (pend_r) begin
        if (walk_idx_r == LW'(1)) begin
          first_ok_nxt = (c == acsn_pkg::CHAR_O);
        end
        if (walk_idx_r == LW'(2)) begin
          second_ok_nxt = (c == acsn_pkg::CHAR_K);
        end
        if (!stop_r) begin
          if (c == acsn_pkg::CHAR_CR) begin
            stop_nxt = 1'b1;
          end else if (is_dec || is_hex) begin
            acc_nxt = {acc_r[27:0], dig};
          end else begin
            bad_nxt  = 1'b1;
            stop_nxt = 1'b1;
          end
        end
      end
      pend_nxt = ram_re;
      if (ram_re) begin
        walk_idx_nxt = walk_idx_r + LW'(1);
      end
    end
  end

  // Advance the sequence by one tick
  always_comb begin
    phase_nxt    = phase_r;
    attempts_nxt = attempts_r;
    idle_nxt     = idle_r;
    len_nxt      = len_r;
    high_nxt     = high_r;
    low_nxt      = low_r;
    finished_nxt = finished_r;
    kind_nxt     = kind_r;
    flush_nxt    = flush_r;
    ram_we       = 1'b0;
    if (cmd.apply) begin
      kind_nxt  = acsn_pkg::TX_NONE;
      flush_nxt = 1'b0;
      if (run) begin
        case (phase_r)
          acsn_pkg::PH_PLUS0: begin
            attempts_nxt = attempts_r + 4'd1;
            len_nxt      = '0;
            idle_nxt     = '0;
            flush_nxt    = 1'b1;
            kind_nxt     = acsn_pkg::TX_PLUS;
            phase_nxt    = acsn_pkg::PH_PLUS1;
          end
          acsn_pkg::PH_PLUS1, acsn_pkg::PH_PLUS2: begin
            flush_nxt = 1'b1;
            kind_nxt  = acsn_pkg::TX_PLUS;
            phase_nxt = phase_r + 4'd1;
          end
          acsn_pkg::PH_OK_RX, acsn_pkg::PH_SH_RX, acsn_pkg::PH_SL_RX: begin
            if (rx_present_r) begin
              if (len_r < LINE_MAX) begin
                ram_we = 1'b1;
                if (rx_data_r == acsn_pkg::CHAR_CR) begin
                  phase_nxt = phase_r + 4'd1;
                end
                len_nxt = len_r + LW'(1);
              end
            end else if (idle_r != 8'hFF) begin
              idle_nxt = idle_r + 8'd1;
            end
            if (idle_nxt > timeout_r || len_nxt >= LINE_MAX) begin
              phase_nxt = acsn_pkg::PH_PLUS0;
            end
          end
          acsn_pkg::PH_OK_CHK: begin
            if (len_r == LW'(3) && first_ok_r && second_ok_r) begin
              kind_nxt  = acsn_pkg::TX_ATSH;
              len_nxt   = '0;
              phase_nxt = acsn_pkg::PH_SH_RX;
            end else begin
              phase_nxt = acsn_pkg::PH_PLUS0;
            end
          end
          acsn_pkg::PH_SH_PARSE: begin
            if (len_r == '0) begin
              phase_nxt = acsn_pkg::PH_PLUS0;
            end else begin
              high_nxt  = parsed;
              kind_nxt  = acsn_pkg::TX_ATSL;
              len_nxt   = '0;
              phase_nxt = acsn_pkg::PH_SL_RX;
            end
          end
          acsn_pkg::PH_SL_PARSE: begin
            if (len_r == '0) begin
              phase_nxt = acsn_pkg::PH_PLUS0;
            end else begin
              low_nxt   = parsed;
              phase_nxt = acsn_pkg::PH_DONE;
            end
          end
          default: begin
            phase_nxt    = acsn_pkg::PH_PLUS0;
            finished_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  // Status seen after the update
  always_comb begin
    if (finished_r) begin
      status_now = acsn_pkg::STAT_FINISHED;
    end else if (attempts_r >= limit_r) begin
      status_now = acsn_pkg::STAT_GAVE_UP;
    end else begin
      status_now = acsn_pkg::STAT_BUSY;
    end
  end

  // Control and sequence registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= acsn_pkg::ATTEMPT_LIMIT_RST;
      timeout_r   <= acsn_pkg::REPLY_TIMEOUT_RST;
      phase_r     <= acsn_pkg::PH_PLUS0;
      attempts_r  <= '0;
      idle_r      <= '0;
      len_r       <= '0;
      high_r      <= '0;
      low_r       <= '0;
      finished_r  <= 1'b0;
      pend_r      <= 1'b0;
      walk_idx_r  <= '0;
      emit_idx_r  <= '0;
      kind_r      <= acsn_pkg::TX_NONE;
      flush_r     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          acsn_pkg::CFG_ATTEMPT_LIMIT: limit_r   <= cfg_wdata[3:0];
          acsn_pkg::CFG_REPLY_TIMEOUT: timeout_r <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r    <= phase_nxt;
      attempts_r <= attempts_nxt;
      idle_r     <= idle_nxt;
      len_r      <= len_nxt;
      high_r     <= high_nxt;
      low_r      <= low_nxt;
      finished_r <= finished_nxt;
      pend_r     <= pend_nxt;
      walk_idx_r <= walk_idx_nxt;
      kind_r     <= kind_nxt;
      flush_r    <= flush_nxt;
      if (cmd.apply) begin
        emit_idx_r <= '0;
      end else if (cmd.emit) begin
        emit_idx_r <= emit_idx_r + 3'd1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx_present_r <= in_rx_present;
      rx_data_r    <= in_rx_data;
    end
    acc_r       <= acc_nxt;
    bad_r       <= bad_nxt;
    stop_r      <= stop_nxt;
    first_ok_r  <= first_ok_nxt;
    second_ok_r <= second_ok_nxt;
    if (cmd.emit) begin
      out_tx_present  <= (kind_r != acsn_pkg::TX_NONE);
      out_tx_data     <= acsn_pkg::tx_byte(kind_r, emit_idx_r);
      out_flush_rx    <= flush_r;
      out_status      <= status_now;
      out_serial_high <= high_r;
      out_serial_low  <= low_r;
      out_last        <= (emit_idx_r == last_idx);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/at_command_serial_number_fetch_top.sv =====
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid/in_ready    in_rx_present, in_rx_data (one poll tick)
// output    out_valid/out_ready  out_tx_present, out_tx_data, out_flush_rx,
//                                out_status, out_serial_high/low, out_last
// config    cfg_wr_en            cfg_index, cfg_wdata (0 attempt limit, 1 reply timeout)
//
// A tick is loaded, then walks the line if needed, is applied and emits its result
// items (1 or 5 items per tick). Ticks that check or parse a reply line walk the
// line store RAM, one registered read a cycle.
// One tick is worked at a time; in_ready returns while the last item waits.
// Reset (synchronous, active low) clears the sequence and loads the register
// defaults; the line store needs no clearing pass. out_ready low stalls emission.
module at_command_serial_number_fetch_top #(
  parameter int LINE_BYTES = acsn_pkg::LINE_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_rx_present,
  input  wire logic [7:0]                     in_rx_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_tx_present,
  output logic [7:0]                          out_tx_data,
  output logic                                out_flush_rx,
  output logic [1:0]                          out_status,
  output logic [31:0]                         out_serial_high,
  output logic [31:0]                         out_serial_low,
  output logic                                out_last,
  input  wire logic                           cfg_wr_en,
  input  wire logic [acsn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata
);

  acsn_pkg::cmd_t cmd;
  acsn_pkg::sts_t sts;

  acsn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acsn_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_rx_present   (in_rx_present),
    .in_rx_data      (in_rx_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_tx_present  (out_tx_present),
    .out_tx_data     (out_tx_data),
    .out_flush_rx    (out_flush_rx),
    .out_status      (out_status),
    .out_serial_high (out_serial_high),
    .out_serial_low  (out_serial_low),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/acsn_chk.sv =====
`default_nettype none

module acsn_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_tx_present,
  input wire logic [7:0] out_tx_data,
  input wire logic       out_flush_rx,
  input wire logic       out_last
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A transaction without a byte carries a zero byte and no flush request
  a_no_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_present |-> out_tx_data == 8'd0 && !out_flush_rx)
    else $error("idle item carries data or flush");

  // Flush only comes with an escape character
  a_flush_plus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flush_rx |-> out_tx_present && out_tx_data == acsn_pkg::CHAR_PLUS
      && out_last)
    else $error("flush without single escape character");

  // A non-final item is followed by more items of the same tick
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("new tick taken inside a command burst");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_data) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind at_command_serial_number_fetch_top acsn_chk u_chk (.*);

`default_nettype wire
